// ===== sv/civil_datetime_to_epoch_macros.svh =====
// Assertion macros for the RTL of the date-time converter.
// Each macro takes a label, a clock, a reset, an antecedent and a consequent.
`ifndef CIVIL_DATETIME_TO_EPOCH_MACROS_SVH
`define CIVIL_DATETIME_TO_EPOCH_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define CDTE_ASSERT_IMP(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("cdte: implication check failed");
// Next-cycle implication.
`define CDTE_ASSERT_NXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("cdte: next-cycle check failed");
`else
`define CDTE_ASSERT_IMP(label, clk_s, rst_s, ante, cons)
`define CDTE_ASSERT_NXT(label, clk_s, rst_s, ante, cons)
`endif

`endif

// ===== sv/cdte_pkg.sv =====
`default_nettype none

package cdte_pkg;

  // Field widths of the input and result transactions.
  localparam int YearW    = 16;
  localparam int MonthW   = 4;
  localparam int DayW     = 5;
  localparam int HourW    = 5;
  localparam int MinuteW  = 6;
  localparam int SecondW  = 6;
  localparam int NsW      = 30;
  localparam int OffsetW  = 18;
  localparam int DaysW    = 25;
  localparam int WdayW    = 3;
  localparam int YdayW    = 9;
  localparam int EpochNsW = 64;

  // Range limits of the month and time-of-day fields.
  localparam logic [MonthW-1:0]  MonthMax  = 4'd12;
  localparam logic [HourW-1:0]   HourMax   = 5'd23;
  localparam logic [MinuteW-1:0] MinSecMax = 6'd59;
  localparam logic [NsW-1:0]     NsMax     = 30'd1000000000;

  // Calendar constants.
  localparam int DaysPerEra   = 146097;
  localparam int EpochShift   = 719468;
  localparam int YearsPerEra  = 400;
  localparam int DaysPerYear  = 365;
  localparam int SecPerDay    = 60 * 60 * 24;
  localparam int NsPerSec     = 1000000000;

  // The shifted year is biased by whole eras so that it is never negative.
  localparam int EraBias      = 83;
  localparam int YearBias     = EraBias * YearsPerEra;
  localparam int ZBias        = EraBias * DaysPerEra + EpochShift;

  // floor(x / 25) for x below 4123 is (x * 5243) >> 17.
  localparam logic [12:0] Recip25      = 13'd5243;
  localparam int          Recip25Shift = 17;

  // Day count bias for the weekday: a multiple of 7 plus the Thursday offset.
  localparam int WdayBias = 7 * 2000000 + 4;

  // Day of the March-based year on which a month starts: (153 * mp + 2) / 5.
  function automatic logic [8:0] month_base(input logic [MonthW-1:0] m);
    logic [8:0] b;
    case (m)
      4'd3:    b = 9'd0;
      4'd4:    b = 9'd31;
      4'd5:    b = 9'd61;
      4'd6:    b = 9'd92;
      4'd7:    b = 9'd122;
      4'd8:    b = 9'd153;
      4'd9:    b = 9'd184;
      4'd10:   b = 9'd214;
      4'd11:   b = 9'd245;
      4'd12:   b = 9'd275;
      4'd1:    b = 9'd306;
      4'd2:    b = 9'd337;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  // Remainder by 7 of a 25-bit value: octal digits sum to the same residue.
  function automatic logic [2:0] mod7_25(input logic [24:0] v);
    logic [5:0] s;
    logic [3:0] t;
    logic [3:0] r;
    s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12]) +
        6'(v[17:15]) + 6'(v[20:18]) + 6'(v[23:21]) + 6'(v[24]);
    t = 4'(s[5:3]) + 4'(s[2:0]);
    if (t >= 4'd14) begin
      r = t - 4'd14;
    end else if (t >= 4'd7) begin
      r = t - 4'd7;
    end else begin
      r = t;
    end
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/cdte_in_if.sv =====
`default_nettype none

// Civil date-time transaction channel.
interface cdte_in_if;
  import cdte_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [YearW-1:0]    year;
  logic        [MonthW-1:0]   month_num;
  logic        [DayW-1:0]     day_num;
  logic        [HourW-1:0]    hour_num;
  logic        [MinuteW-1:0]  minute_num;
  logic        [SecondW-1:0]  second_num;
  logic        [NsW-1:0]      nanosecond_num;
  logic signed [OffsetW-1:0]  utc_offset;

  modport source (
    output valid, year, month_num, day_num, hour_num, minute_num, second_num,
           nanosecond_num, utc_offset,
    input  ready
  );

  modport sink (
    input  valid, year, month_num, day_num, hour_num, minute_num, second_num,
           nanosecond_num, utc_offset,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/cdte_out_if.sv =====
`default_nettype none

// Epoch result transaction channel.
interface cdte_out_if;
  import cdte_pkg::*;

  logic                        valid;
  logic                        ready;
  logic                        fields_ok;
  logic                        day_ok;
  logic signed [DaysW-1:0]     epoch_days;
  logic        [WdayW-1:0]     weekday;
  logic        [YdayW-1:0]     year_day;
  logic signed [EpochNsW-1:0]  epoch_ns;
  logic                        overflow;

  modport source (
    output valid, fields_ok, day_ok, epoch_days, weekday, year_day,
           epoch_ns, overflow,
    input  ready
  );

  modport sink (
    input  valid, fields_ok, day_ok, epoch_days, weekday, year_day,
           epoch_ns, overflow,
    output ready
  );
endinterface

`default_nettype wire

// ===== sv/civil_datetime_to_epoch.sv =====
// Channel  Modport             Carries
// civil    cdte_in_if.sink     date, time of day, nanoseconds, UTC offset
// epoch    cdte_out_if.source  validity flags, day count, weekday, day of year, ns
//
// Seven register stages; one transaction enters per cycle unless every stage
// is full and the result side stalls. The clock rate is set by the slowest
// stage, the 43-bit by 30-bit second to nanosecond product, which is split
// into two partial products summed in the next stage. Reset clears only the
// stage valid bits. A stage holds while the one after it is full and stalled,
// so empty stages still fill up.
`default_nettype none
`include "civil_datetime_to_epoch_macros.svh"

module civil_datetime_to_epoch (
  input  wire         clk,
  input  wire         rst,
  cdte_in_if.sink     civil,
  cdte_out_if.source  epoch
);
  import cdte_pkg::*;

  localparam int NumStages = 7;

  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] en;

  // Stage 0 registers.
  logic                fok_s0, dok_s0;
  logic [16:0]         yp_s0;
  logic signed [9:0]   doy_s0;
  logic signed [19:0]  tods_s0;
  logic [NsW-1:0]      nsec_s0;

  // Stage 1 registers.
  logic                fok_s1, dok_s1;
  logic [16:0]         yp_s1;
  logic [7:0]          era_s1;
  logic signed [9:0]   doy_s1;
  logic signed [19:0]  tods_s1;
  logic [NsW-1:0]      nsec_s1;

  // Stage 2 registers.
  logic                fok_s2, dok_s2;
  logic [8:0]          yoe_s2;
  logic [24:0]         erad_s2;
  logic signed [9:0]   doy_s2;
  logic signed [19:0]  tods_s2;
  logic [NsW-1:0]      nsec_s2;

  // Stage 3 registers.
  logic                fok_s3, dok_s3;
  logic signed [24:0]  z_s3;
  logic [YdayW-1:0]    dy_s3;
  logic signed [19:0]  tods_s3;
  logic [NsW-1:0]      nsec_s3;

  // Stage 4 registers.
  logic                fok_s4, dok_s4;
  logic signed [24:0]  z_s4;
  logic [YdayW-1:0]    dy_s4;
  logic [WdayW-1:0]    wd_s4;
  logic signed [42:0]  secs_s4;
  logic [NsW-1:0]      nsec_s4;

  // Stage 5 registers.
  logic                fok_s5, dok_s5;
  logic signed [24:0]  z_s5;
  logic [YdayW-1:0]    dy_s5;
  logic [WdayW-1:0]    wd_s5;
  logic signed [50:0]  phi_s5;
  logic [51:0]         plo_s5;
  logic [NsW-1:0]      nsec_s5;

  // Output registers.
  logic                     fok_o, dok_o, ovf_o;
  logic signed [DaysW-1:0]  days_o;
  logic [WdayW-1:0]         wd_o;
  logic [YdayW-1:0]         dy_o;
  logic [EpochNsW-1:0]      ens_o;

  // Combinational values between stages.
  logic                mon_le2;
  logic [17:0]         yb_c;
  logic [17:0]         tod_c;
  logic signed [19:0]  tods_c;
  logic signed [9:0]   doy_c;
  logic                fok_c;
  logic [25:0]         qprod_c;
  logic [8:0]          yoe_c;
  logic [24:0]         erad_c;
  logic [1:0]          c100_c;
  logic [17:0]         doe_u_c;
  logic signed [18:0]  doe_c;
  logic signed [25:0]  z_c;
  logic                leap_c;
  logic signed [9:0]   dsum_c;
  logic signed [41:0]  zsec_c;
  logic signed [42:0]  secs_c;
  logic [25:0]         zp_c;
  logic signed [50:0]  phi_c;
  logic [51:0]         plo_c;
  logic signed [73:0]  sum_c;
  logic                ovf_c;

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[NumStages-1] = !vld[NumStages-1] || epoch.ready;
    for (int i = NumStages - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign civil.ready = en[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= civil.valid;
      for (int i = 1; i < NumStages; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // Stage 0: range checks, March-based year with era bias, day of the
  // March-based year and the local time of day as seconds less the offset.
  always_comb begin
    mon_le2 = civil.month_num <= 4'd2;
    yb_c    = {{2{civil.year[15]}}, civil.year} + 18'(YearBias) - {17'b0, mon_le2};
    doy_c   = $signed({1'b0, month_base(civil.month_num)}) +
              $signed({5'b0, civil.day_num}) - 10'sd1;
    tod_c   = 18'(civil.hour_num) * 18'd3600 + 18'(civil.minute_num) * 18'd60 +
              18'(civil.second_num);
    tods_c  = $signed({2'b0, tod_c}) - 20'(civil.utc_offset);
    fok_c   = civil.month_num != '0 && civil.month_num <= MonthMax &&
              civil.hour_num <= HourMax && civil.minute_num <= MinSecMax &&
              civil.second_num <= MinSecMax && civil.nanosecond_num <= NsMax;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      fok_s0  <= fok_c;
      dok_s0  <= civil.day_num != '0;
      yp_s0   <= yb_c[16:0];
      doy_s0  <= doy_c;
      tods_s0 <= tods_c;
      nsec_s0 <= civil.nanosecond_num;
    end
  end

  // Stage 1: biased era as floor(year / 400) = floor((year >> 4) / 25).
  assign qprod_c = yp_s0[16:4] * Recip25;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      fok_s1  <= fok_s0;
      dok_s1  <= dok_s0;
      yp_s1   <= yp_s0;
      era_s1  <= qprod_c[Recip25Shift +: 8];
      doy_s1  <= doy_s0;
      tods_s1 <= tods_s0;
      nsec_s1 <= nsec_s0;
    end
  end

  // Stage 2: year of era and the day count of the whole eras.
  assign yoe_c  = 9'(yp_s1 - 17'(era_s1 * 17'(YearsPerEra)));
  assign erad_c = 25'(era_s1) * 25'(DaysPerEra);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      fok_s2  <= fok_s1;
      dok_s2  <= dok_s1;
      yoe_s2  <= yoe_c;
      erad_s2 <= erad_c;
      doy_s2  <= doy_s1;
      tods_s2 <= tods_s1;
      nsec_s2 <= nsec_s1;
    end
  end

  // Stage 3: day of era, days since the epoch, leap year and day of year.
  always_comb begin
    if (yoe_s2 >= 9'd300) begin
      c100_c = 2'd3;
    end else if (yoe_s2 >= 9'd200) begin
      c100_c = 2'd2;
    end else if (yoe_s2 >= 9'd100) begin
      c100_c = 2'd1;
    end else begin
      c100_c = 2'd0;
    end
    doe_u_c = 18'(yoe_s2) * 18'(DaysPerYear) + 18'(yoe_s2[8:2]) - 18'(c100_c);
    doe_c   = $signed({1'b0, doe_u_c}) + 19'(doy_s2);
    z_c     = $signed({1'b0, erad_s2}) + 26'(doe_c) - 26'(ZBias);
    // The era is a multiple of 400 years, so the leap rule can use the
    // year of era alone; a century year is a leap year only at era start.
    leap_c  = yoe_s2[1:0] == 2'b00 &&
              !(yoe_s2 == 9'd100 || yoe_s2 == 9'd200 || yoe_s2 == 9'd300);
    // January and February close the March-based year.
    if (doy_s2 > 10'sd305) begin
      dsum_c = doy_s2 - 10'sd306;
    end else begin
      dsum_c = doy_s2 + 10'sd59 + $signed({9'b0, leap_c});
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      fok_s3  <= fok_s2;
      dok_s3  <= dok_s2;
      z_s3    <= z_c[24:0];
      dy_s3   <= dsum_c[8:0];
      tods_s3 <= tods_s2;
      nsec_s3 <= nsec_s2;
    end
  end

  // Stage 4: seconds since the epoch at UTC and the weekday.
  always_comb begin
    zsec_c = z_s3 * $signed(18'(SecPerDay));
    secs_c = 43'(zsec_c) + 43'(tods_s3);
    zp_c   = 26'(z_s3) + 26'(WdayBias);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      fok_s4  <= fok_s3;
      dok_s4  <= dok_s3;
      z_s4    <= z_s3;
      dy_s4   <= dy_s3;
      wd_s4   <= mod7_25(zp_c[24:0]);
      secs_s4 <= secs_c;
      nsec_s4 <= nsec_s3;
    end
  end

  // Stage 5: seconds times one billion as two partial products.
  assign plo_c = 52'(secs_s4[21:0]) * 52'(NsPerSec);
  assign phi_c = $signed(secs_s4[42:22]) * $signed(31'(NsPerSec));

  always_ff @(posedge clk) begin
    if (en[5]) begin
      fok_s5  <= fok_s4;
      dok_s5  <= dok_s4;
      z_s5    <= z_s4;
      dy_s5   <= dy_s4;
      wd_s5   <= wd_s4;
      phi_s5  <= phi_c;
      plo_s5  <= plo_c;
      nsec_s5 <= nsec_s4;
    end
  end

  // Stage 6: exact nanosecond sum; overflow when the top bits are not
  // all copies of the 64-bit sign bit. Results are zero for bad fields.
  always_comb begin
    sum_c = (74'(phi_s5) <<< 22) + $signed({22'b0, plo_s5}) +
            $signed({44'b0, nsec_s5});
    ovf_c = !(&sum_c[73:63] || ~|sum_c[73:63]);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      fok_o <= fok_s5;
      dok_o <= dok_s5;
      if (fok_s5) begin
        days_o <= z_s5;
        wd_o   <= wd_s5;
        dy_o   <= dy_s5;
        ens_o  <= sum_c[63:0];
        ovf_o  <= ovf_c;
      end else begin
        days_o <= '0;
        wd_o   <= '0;
        dy_o   <= '0;
        ens_o  <= '0;
        ovf_o  <= 1'b0;
      end
    end
  end

  assign epoch.valid      = vld[NumStages-1];
  assign epoch.fields_ok  = fok_o;
  assign epoch.day_ok     = dok_o;
  assign epoch.epoch_days = days_o;
  assign epoch.weekday    = wd_o;
  assign epoch.year_day   = dy_o;
  assign epoch.epoch_ns   = ens_o;
  assign epoch.overflow   = ovf_o;

  // An accepted transaction always lands in the first stage.
  `CDTE_ASSERT_NXT(a_accept_enters, clk, rst, civil.valid && civil.ready, vld[0])
  // Time results of a transaction with bad fields are cleared.
  `CDTE_ASSERT_IMP(a_bad_fields_ns, clk, rst, vld[6] && !fok_o, {ens_o, ovf_o} == '0)
  // Calendar results of a transaction with bad fields are cleared.
  `CDTE_ASSERT_IMP(a_bad_fields_days, clk, rst, vld[6] && !fok_o, {days_o, wd_o, dy_o} == '0)
  // Weekday and day of year stay inside their calendar ranges.
  `CDTE_ASSERT_IMP(a_calendar_range, clk, rst, epoch.valid, wd_o <= 3'd6 && dy_o <= 9'd365)
  // A full stage that cannot move keeps its transaction.
  `CDTE_ASSERT_NXT(a_stage_holds, clk, rst, vld[5] && !en[5], vld[5])

endmodule

`default_nettype wire

// ===== tb/tb_civil_datetime_to_epoch.sv =====
module tb_civil_datetime_to_epoch;
  timeunit 1ns;
  timeprecision 1ps;

  import cdte_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int ResetCycles = 10;
  localparam int RandItems = 850;
  localparam int LongHold = 100;
  localparam int HoldAfter = 200;
  localparam int DrainCycles = 30;
  localparam int StallLimit = 2000;
  localparam int MaxReports = 10;

  // Limits of the nanosecond count that fit in 64 signed bits.
  localparam longint SecHi = 64'sd9223372036;
  localparam longint SecLo = -64'sd9223372037;
  localparam logic [NsW-1:0] NsHi = 30'd854775807;
  localparam logic [NsW-1:0] NsLo = 30'd145224192;

  typedef struct packed {
    logic signed [YearW-1:0]   year;
    logic        [MonthW-1:0]  month_num;
    logic        [DayW-1:0]    day_num;
    logic        [HourW-1:0]   hour_num;
    logic        [MinuteW-1:0] minute_num;
    logic        [SecondW-1:0] second_num;
    logic        [NsW-1:0]     nanosecond_num;
    logic signed [OffsetW-1:0] utc_offset;
  } civil_t;

  typedef struct packed {
    logic                fields_ok;
    logic                day_ok;
    logic [DaysW-1:0]    epoch_days;
    logic [WdayW-1:0]    weekday;
    logic [YdayW-1:0]    year_day;
    logic [EpochNsW-1:0] epoch_ns;
    logic                overflow;
  } epoch_t;

  // One row of the directed table; want is used only where given is set.
  typedef struct packed {
    civil_t stim;
    logic   given;
    epoch_t want;
  } dir_row_t;

  localparam epoch_t Computed = '0;
  localparam epoch_t BadFieldsDayOk = epoch_t'{1'b0, 1'b1, '0, '0, '0, '0, 1'b0};
  localparam epoch_t BadFieldsDayZero = '0;

  logic clk = 1'b0;
  logic rst;
  logic rx_hold = 1'b0;

  epoch_t pending_epochs[$];
  int errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_bad_fields = 0;
  int n_day_zero = 0;
  int n_overflow = 0;

  cdte_in_if civil ();
  cdte_out_if epoch ();

  civil_datetime_to_epoch DUT (
    .clk  (clk),
    .rst  (rst),
    .civil(civil),
    .epoch(epoch)
  );

  always begin
    clk = 1'b0;
    #(HalfPeriod);
    clk = 1'b1;
    #(HalfPeriod);
  end

  // Days from civil over 400-year eras, then weekday, day of year and epoch nanoseconds.
  function automatic epoch_t civil_to_epoch(civil_t c);
    epoch_t r;
    int y, era, yoe, mp, doy, doe, z, wd, dy;
    logic leap;
    longint secs;
    r = '0;
    r.fields_ok = c.month_num >= 4'd1 && c.month_num <= MonthMax && c.hour_num <= HourMax &&
                  c.minute_num <= MinSecMax && c.second_num <= MinSecMax &&
                  c.nanosecond_num <= NsMax;
    r.day_ok = c.day_num != '0;
    if (r.fields_ok) begin
      // The year is taken to start on March 1.
      y = int'($signed(c.year)) - ((c.month_num <= 4'd2) ? 1 : 0);
      era = ((y >= 0) ? y : y - (YearsPerEra - 1)) / YearsPerEra;
      yoe = y - era * YearsPerEra;
      mp = (c.month_num > 4'd2) ? int'(c.month_num) - 3 : int'(c.month_num) + 9;
      doy = (153 * mp + 2) / 5 + int'(c.day_num) - 1;
      doe = yoe * DaysPerYear + yoe / 4 - yoe / 100 + doy;
      z = era * DaysPerEra + doe - EpochShift;
      wd = (z + 4) % 7;
      if (wd < 0) begin
        wd += 7;
      end
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      dy = (doy > 305) ? doy - 306 : doy + 59 + (leap ? 1 : 0);
      secs = longint'(z) * SecPerDay + longint'(c.hour_num) * 3600 +
             longint'(c.minute_num) * 60 + longint'(c.second_num) -
             longint'($signed(c.utc_offset));
      r.epoch_days = DaysW'(z);
      r.weekday = WdayW'(wd);
      r.year_day = YdayW'(dy);
      r.overflow = secs > SecHi || (secs == SecHi && c.nanosecond_num > NsHi) ||
                   secs < SecLo || (secs == SecLo && c.nanosecond_num < NsLo);
      r.epoch_ns = 64'(secs) * 64'(NsPerSec) + 64'(c.nanosecond_num);
    end
    return r;
  endfunction

  // Mostly well-formed date-times near the representable span, with some garbage fields.
  function automatic civil_t random_civil();
    civil_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      c.year = 16'($urandom_range(1678, 2261));
    end else if (pick < 75) begin
      c.year = 16'($urandom_range(1500, 2500));
    end else begin
      c.year = 16'($urandom);
    end
    c.month_num = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
    c.day_num = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 28));
    c.hour_num = ($urandom_range(0, 19) == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
    c.minute_num = ($urandom_range(0, 19) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
    c.second_num = ($urandom_range(0, 19) == 0) ? 6'($urandom) : 6'($urandom_range(0, 59));
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      c.nanosecond_num = 30'($urandom);
    end else if (pick == 1) begin
      c.nanosecond_num = NsMax;
    end else if (pick == 2) begin
      c.nanosecond_num = '0;
    end else begin
      c.nanosecond_num = 30'($urandom_range(0, NsPerSec - 1));
    end
    if ($urandom_range(0, 4) == 0) begin
      c.utc_offset = 18'($urandom);
    end else begin
      c.utc_offset = 18'($urandom_range(0, 2 * (SecPerDay - 1)) - (SecPerDay - 1));
    end
    return c;
  endfunction

  // Offers one date-time, waits for its transaction, and files the expected result.
  // Entered and left at a falling edge.
  task automatic send_civil(input civil_t c, input logic given, input epoch_t want);
    int gap;
    if (rx_hold || (n_sent / 40) % 4 == 3) begin
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
    end
    if (gap != 0) begin
      civil.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    civil.valid = 1'b1;
    civil.year = c.year;
    civil.month_num = c.month_num;
    civil.day_num = c.day_num;
    civil.hour_num = c.hour_num;
    civil.minute_num = c.minute_num;
    civil.second_num = c.second_num;
    civil.nanosecond_num = c.nanosecond_num;
    civil.utc_offset = c.utc_offset;
    do @(posedge clk); while (!civil.ready);
    pending_epochs.push_back(given ? want : civil_to_epoch(c));
    n_sent++;
    @(negedge clk);
  endtask

  function automatic void show_epoch(string tag, epoch_t r);
    $display("  %s ok=%0b day_ok=%0b days=%0d wday=%0d yday=%0d ns=%0d ovf=%0b", tag,
             r.fields_ok, r.day_ok, $signed(r.epoch_days), r.weekday,
             r.year_day, $signed(r.epoch_ns), r.overflow);
  endfunction

  // Result side: random stalls, quiet stretches, and one long hold-off.
  initial begin : result_sink
    int gap;
    logic held;
    held = 1'b0;
    epoch.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (!held && n_results >= HoldAfter) begin
        gap = LongHold;
        held = 1'b1;
        rx_hold = 1'b1;
      end else if ((n_results / 50) % 4 == 1) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 16);
      end
      if (gap != 0) begin
        epoch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      rx_hold = 1'b0;
      epoch.ready = 1'b1;
      do @(posedge clk); while (!epoch.valid);
      @(negedge clk);
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : check_results
    epoch_t got;
    epoch_t want;
    if (!rst && epoch.valid && epoch.ready) begin
      got.fields_ok = epoch.fields_ok;
      got.day_ok = epoch.day_ok;
      got.epoch_days = epoch.epoch_days;
      got.weekday = epoch.weekday;
      got.year_day = epoch.year_day;
      got.epoch_ns = epoch.epoch_ns;
      got.overflow = epoch.overflow;
      if (pending_epochs.size() == 0) begin
        errors++;
        if (errors <= MaxReports) begin
          $display("Unexpected result transaction at %0t", $realtime);
          show_epoch("actual:  ", got);
        end
      end else begin
        want = pending_epochs.pop_front();
        if (!want.fields_ok) n_bad_fields++;
        if (!want.day_ok) n_day_zero++;
        if (want.overflow) n_overflow++;
        if (got.fields_ok !== want.fields_ok || got.day_ok !== want.day_ok ||
            got.epoch_days !== want.epoch_days ||
            got.weekday !== want.weekday || got.year_day !== want.year_day ||
            got.epoch_ns !== want.epoch_ns || got.overflow !== want.overflow) begin
          errors++;
          if (errors <= MaxReports) begin
            $display("Mismatch on result %0d at %0t", n_results, $realtime);
            show_epoch("expected:", want);
            show_epoch("actual:  ", got);
          end
        end
      end
      n_results++;
    end
  end

  // Ends the run when no transaction moves on either side for too long.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk);
      if (rst || (civil.valid && civil.ready) || (epoch.valid && epoch.ready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("Timeout: no transaction for %0d cycles", StallLimit);
    $display("tb_civil_datetime_to_epoch failed");
    $finish;
  end

  initial begin : stimulus
    dir_row_t dir_rows[$];
    rst = 1'b1;
    civil.valid = 1'b0;
    civil.year = '0;
    civil.month_num = '0;
    civil.day_num = '0;
    civil.hour_num = '0;
    civil.minute_num = '0;
    civil.second_num = '0;
    civil.nanosecond_num = '0;
    civil.utc_offset = '0;

    // The epoch itself, the next day, and the last second before it with a nanosecond count of NsMax.
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 30'd0, 18'sd0},
                       1'b1, epoch_t'{1'b1, 1'b1, 25'd0, 3'd4, 9'd0, 64'd0, 1'b0}});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd1970, 4'd1, 5'd2, 5'd0, 6'd0, 6'd0, 30'd0, 18'sd0},
                       1'b1, epoch_t'{1'b1, 1'b1, 25'd1, 3'd5, 9'd1, 64'd86400000000000, 1'b0}});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd1969, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, NsMax,
                       18'sd0}, 1'b1, epoch_t'{1'b1, 1'b1, -25'sd1, 3'd3, 9'd364, 64'd0, 1'b0}});
    // Each out-of-range field zeroes the results; day_ok is still reported.
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd2000, 4'd0, 5'd15, 5'd12, 6'd30, 6'd30, 30'd5,
                       18'sd0}, 1'b1, BadFieldsDayOk});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd2000, 4'd13, 5'd0, 5'd12, 6'd30, 6'd30, 30'd5,
                       18'sd0}, 1'b1, BadFieldsDayZero});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd2000, 4'd6, 5'd15, 5'd24, 6'd0, 6'd0, 30'd0,
                       18'sd0}, 1'b1, BadFieldsDayOk});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd2000, 4'd6, 5'd15, 5'd0, 6'd60, 6'd0, 30'd0,
                       18'sd0}, 1'b1, BadFieldsDayOk});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd2000, 4'd6, 5'd15, 5'd0, 6'd0, 6'd60, 30'd0,
                       18'sd0}, 1'b1, BadFieldsDayOk});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd2000, 4'd6, 5'd15, 5'd0, 6'd0, 6'd0, NsMax + 30'd1,
                       18'sd0}, 1'b1, BadFieldsDayOk});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sh7FFF, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63,
                       30'h3FFFFFFF, 18'sh1FFFF}, 1'b1, BadFieldsDayOk});
    // Year extremes with offset extremes; both overflow.
    dir_rows.push_back(dir_row_t'{civil_t'{16'sh8000, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 30'd0,
                       18'sh1FFFF}, 1'b0, Computed});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sh7FFF, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59,
                       30'd999999999, 18'sh20000}, 1'b0, Computed});
    // Leap and non-leap February, days past the month end, and day zero.
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd2000, 4'd2, 5'd29, 5'd6, 6'd7, 6'd8, 30'd9,
                       18'sd3600}, 1'b0, Computed});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd1900, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 30'd0,
                       18'sd0}, 1'b0, Computed});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd2023, 4'd2, 5'd31, 5'd12, 6'd0, 6'd0, 30'd0,
                       18'sd0}, 1'b0, Computed});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd2024, 4'd3, 5'd0, 5'd0, 6'd0, 6'd0, 30'd0,
                       18'sd0}, 1'b0, Computed});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd2024, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0, 30'd0,
                       18'sd0}, 1'b0, Computed});
    // Both edges of the 64-bit nanosecond range.
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd2262, 4'd4, 5'd11, 5'd23, 6'd47, 6'd16, NsHi,
                       18'sd0}, 1'b0, Computed});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd2262, 4'd4, 5'd11, 5'd23, 6'd47, 6'd16,
                       NsHi + 30'd1, 18'sd0}, 1'b0, Computed});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd1677, 4'd9, 5'd21, 5'd0, 6'd12, 6'd43, NsLo,
                       18'sd0}, 1'b0, Computed});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd1677, 4'd9, 5'd21, 5'd0, 6'd12, 6'd43,
                       NsLo - 30'd1, 18'sd0}, 1'b0, Computed});
    // Offsets at the usual limits and at the negative end of the field.
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 30'd0,
                       18'sd86399}, 1'b0, Computed});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 30'd0,
                       -18'sd86399}, 1'b0, Computed});
    dir_rows.push_back(dir_row_t'{civil_t'{16'sd1999, 4'd7, 5'd4, 5'd18, 6'd30, 6'd0, 30'd1,
                       18'sh20000}, 1'b0, Computed});

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[k]) begin
      send_civil(dir_rows[k].stim, dir_rows[k].given, dir_rows[k].want);
    end

    for (int i = 0; i < RandItems; i++) begin
      // Once, halfway through, let the pipeline drain completely.
      if (i == RandItems / 2) begin
        civil.valid = 1'b0;
        while (pending_epochs.size() != 0) @(negedge clk);
      end
      send_civil(random_civil(), 1'b0, Computed);
    end
    civil.valid = 1'b0;

    while (pending_epochs.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    errors += pending_epochs.size();

    $display("Sent %0d date-times (%0d directed); %0d results checked.", n_sent,
             dir_rows.size(), n_results);
    $display("Results with bad fields: %0d, on day zero: %0d, overflowing: %0d.",
             n_bad_fields, n_day_zero, n_overflow);
    if (errors == 0) begin
      $display("tb_civil_datetime_to_epoch passed");
    end else begin
      $display("%0d failing checks", errors);
      $display("tb_civil_datetime_to_epoch failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/cdte_pkg.sv
sv/cdte_in_if.sv
sv/cdte_out_if.sv
sv/civil_datetime_to_epoch.sv
tb/tb_civil_datetime_to_epoch.sv
